@@ design/ook_pulse_width_decoder_defines.svh @@
// Assertion macros for the decoder RTL.
`ifndef OOK_PULSE_WIDTH_DECODER_DEFINES_SVH
`define OOK_PULSE_WIDTH_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define OPWD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define OPWD_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);
`else
`define OPWD_ASSERT(label, prop, msg)
`define OPWD_ASSERT_NEXT(label, trig, cons, msg)
`endif
`endif

@@ design/opwd_pkg.sv @@
`default_nettype none
package opwd_pkg;

  localparam int MAX_EDGES      = 128;
  localparam int INTERVAL_WIDTH = 16;
  localparam int IW             = INTERVAL_WIDTH;
  localparam int EDGE_AW        = $clog2(MAX_EDGES);
  localparam int PIW            = EDGE_AW + 1;

  localparam int TOL_W   = 7;
  localparam int MS_W    = 16;
  localparam int TICKS_W = 16;

  localparam int PW       = IW + TOL_W;
  localparam int QW       = PW - 6;
  localparam int BW       = IW + 2;
  localparam int PCT_DEN  = 100;
  localparam int PCT_HI   = 75;
  localparam int PCT_LO   = 25;
  localparam int BASE_SHIFT = 3;
  localparam int RS       = PW + 7;
  localparam longint unsigned RECIP = ((64'd1 << RS) + PCT_DEN - 1) / PCT_DEN;
  localparam int RECIP_W  = RS - 6;
  localparam int DW       = PW + RECIP_W;

  localparam int RESULT_LIMIT = 8;
  localparam int RLW          = $clog2(RESULT_LIMIT);
  localparam int NBW          = $clog2(MAX_EDGES / 16 + RESULT_LIMIT + 2);

  localparam int DATA_W  = 8;
  localparam int BIDX_W  = 6;
  localparam int BCNT_W  = 7;
  localparam int SYNC_W  = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_IVAL_LSB = 0;
  localparam int IN_PIN_BIT  = IN_IVAL_LSB + TICKS_W;
  localparam int IN_IDLE_LSB = IN_PIN_BIT + 1;

  localparam int OUT_BIDX_LSB = DATA_W;
  localparam int OUT_BCNT_LSB = OUT_BIDX_LSB + BIDX_W;
  localparam int OUT_SYNC_LSB = OUT_BCNT_LSB + BCNT_W;
  localparam int OUT_PAD_LSB  = OUT_SYNC_LSB + SYNC_W;

  localparam logic [TOL_W-1:0] TOL_RESET     = 7'd20;
  localparam logic [MS_W-1:0]  MIN_GAP_RESET = 16'd5;
  localparam logic [MS_W-1:0]  TIMEOUT_RESET = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOL     = 2'd0,
    REG_MIN_GAP = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_POLL = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    OP_SYNC   = 3'd0,
    OP_HI     = 3'd1,
    OP_LO     = 3'd2,
    OP_HI_TOL = 3'd3,
    OP_LO_TOL = 3'd4
  } op_t;

  typedef struct packed {
    logic edge_upd;
    logic drop;
    logic start;
    logic mul;
    logic div;
    logic load;
    logic rd_b;
    logic shift;
    logic finish;
    logic emit_next;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic frame_open;
    logic frame_closed;
    logic timeout;
    logic sync_ok;
    logic pair_avail;
    logic pair_ok;
    logic out_last;
  } dp_sts_t;

  function automatic logic [BW-1:0] lo_bnd(input logic [IW-1:0] v, input logic [QW-1:0] d);
    logic [BW-1:0] ve;
    logic [BW-1:0] de;
    ve = BW'(v);
    de = BW'(d);
    return (de > ve) ? '0 : ve - de;
  endfunction

  function automatic logic [BW-1:0] hi_bnd(input logic [IW-1:0] v, input logic [QW-1:0] d);
    return BW'(v) + BW'(d);
  endfunction

  function automatic logic near(input logic [IW-1:0] x, input logic [BW-1:0] lb,
                                input logic [BW-1:0] ub);
    return (BW'(x) >= lb) && (BW'(x) <= ub);
  endfunction

endpackage
`default_nettype wire

@@ design/ook_pulse_width_decoder.sv @@
`default_nettype none
// On-off keyed pulse-width decoder. Edge transactions (tuser 0) and polls that find nothing
// to decode are handled in the idle state. A poll on a closed frame runs a decode: a start
// step, then the sync check and the 75/25 percent bounds built through one shared multiply
// and reciprocal-divide unit (a multiply, a divide and a load step per term, five terms),
// then each interval pair read through the one read port of the interval RAM (up to 63
// pairs), a step to find the pairs used up (none when a pair fails to match), a step to
// close, and one result per cycle while out_tready is high. A sync mismatch drops the frame
// at the end of the sync term with no result.
// in_tready is low from the start of a decode until its last result is taken or the frame is
// dropped. cfg_ready is always high; write registers only between transactions. The interval
// RAM needs no clearing after reset.
`include "ook_pulse_width_decoder_defines.svh"
module ook_pulse_width_decoder (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [15:0] interval_ticks, [16] pin_high, [32:17] idle_ms, [39:33] zero
  input  wire logic [opwd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] command
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] data_byte, [13:8] byte_index, [20:14] byte_count, [36:21] sync_ticks, [39:37] zero
  output logic      [opwd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [opwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [opwd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import opwd_pkg::*;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [DATA_W-1:0]   data_byte;
  logic [BIDX_W-1:0]   byte_index;
  logic [BCNT_W-1:0]   byte_count;
  logic [SYNC_W-1:0]   sync_ticks;

  assign cfg_ready = 1'b1;

  opwd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_command (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  opwd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ival        (in_tdata[IN_IVAL_LSB +: TICKS_W]),
    .in_pin         (in_tdata[IN_PIN_BIT]),
    .in_idle        (in_tdata[IN_IDLE_LSB +: MS_W]),
    .cmd            (cmd),
    .sts            (sts),
    .out_data_byte  (data_byte),
    .out_byte_index (byte_index),
    .out_byte_count (byte_count),
    .out_sync_ticks (sync_ticks)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_PAD_LSB)'(0), sync_ticks, byte_count, byte_index,
                      data_byte};
  assign out_tlast = sts.out_last;

  `OPWD_ASSERT(a_one_side, !(in_tready && out_tvalid), "input and output active together")
  `OPWD_ASSERT_NEXT(a_more_results, out_tvalid && out_tready && !out_tlast, out_tvalid,
    "frame results stopped before last")
  `OPWD_ASSERT_NEXT(a_back_idle, out_tvalid && out_tready && out_tlast, in_tready,
    "not ready after last result")
  `OPWD_ASSERT_NEXT(a_decode_busy,
    in_tvalid && in_tready && (in_tuser == CMD_POLL) && sts.frame_closed, !in_tready,
    "decode poll did not start a decode")

endmodule
`default_nettype wire

@@ design/opwd_ram.sv @@
`default_nettype none
module opwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/opwd_ctrl.sv @@
`default_nettype none
module opwd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_command,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output opwd_pkg::dp_cmd_t      cmd,
  input  wire opwd_pkg::dp_sts_t sts
);

  import opwd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_DIV    = 9'b000000100,
    S_LOAD   = 9'b000001000,
    S_PAIR_A = 9'b000010000,
    S_PAIR_B = 9'b000100000,
    S_PAIR_C = 9'b001000000,
    S_FINISH = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd        = '0;
    cmd.op     = op_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_command == CMD_EDGE) begin
            cmd.edge_upd = 1'b1;
          end else if (sts.frame_open && !sts.frame_closed) begin
            cmd.drop = sts.timeout;
          end else if (sts.frame_closed) begin
            cmd.start = 1'b1;
            op_nxt    = OP_SYNC;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_MUL;
        unique case (op_r)
          OP_SYNC: begin
            if (!sts.sync_ok) begin
              cmd.drop  = 1'b1;
              state_nxt = S_IDLE;
            end
            op_nxt = OP_HI;
          end
          OP_HI:     op_nxt = OP_LO;
          OP_LO:     op_nxt = OP_HI_TOL;
          OP_HI_TOL: op_nxt = OP_LO_TOL;
          OP_LO_TOL: state_nxt = S_PAIR_A;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_PAIR_A: begin
        state_nxt = sts.pair_avail ? S_PAIR_B : S_FINISH;
      end
      S_PAIR_B: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_PAIR_C;
      end
      S_PAIR_C: begin
        if (sts.pair_ok) begin
          cmd.shift = 1'b1;
          state_nxt = S_PAIR_A;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.out_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_SYNC;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/opwd_dp.sv @@
`default_nettype none
module opwd_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [opwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [opwd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [opwd_pkg::TICKS_W-1:0]       in_ival,
  input  wire logic                               in_pin,
  input  wire logic [opwd_pkg::MS_W-1:0]          in_idle,
  input  wire opwd_pkg::dp_cmd_t                  cmd,
  output opwd_pkg::dp_sts_t                       sts,
  output logic      [opwd_pkg::DATA_W-1:0]        out_data_byte,
  output logic      [opwd_pkg::BIDX_W-1:0]        out_byte_index,
  output logic      [opwd_pkg::BCNT_W-1:0]        out_byte_count,
  output logic      [opwd_pkg::SYNC_W-1:0]        out_sync_ticks
);

  import opwd_pkg::*;

  logic [TOL_W-1:0]   tol_r;
  logic [MS_W-1:0]    min_gap_r;
  logic [MS_W-1:0]    timeout_r;

  logic               frame_open_r;
  logic               frame_closed_r;
  logic [EDGE_AW-1:0] edge_count_r;
  logic [IW-1:0]      sync_r;
  logic [IW-1:0]      end_r;

  logic [PW-1:0]      prod_r;
  logic [QW-1:0]      q_r;
  logic [IW-1:0]      hi_r;
  logic [IW-1:0]      lo_r;
  logic [BW-1:0]      hi_lb_r, hi_ub_r, lo_lb_r, lo_ub_r;

  logic [PIW-1:0]     pair_r;
  logic [IW-1:0]      a_r;
  logic [DATA_W-1:0]  acc_r;
  logic [2:0]         nbits_r;
  logic [NBW-1:0]     nbytes_r;
  logic [DATA_W-1:0]  byte_buf_r [RESULT_LIMIT];
  logic [NBW-1:0]     emit_idx_r;

  logic [IW-1:0]      ival;
  logic               gap_end;
  logic               ram_we;
  logic [EDGE_AW-1:0] ram_raddr;
  logic [IW-1:0]      ram_rdata;
  logic [PIW-1:0]     pair_p1;
  logic [IW-1:0]      base;
  logic [IW-1:0]      mul_v;
  logic [TOL_W-1:0]   mul_k;
  logic [DW-1:0]      recip_prod;
  logic               bit_one, bit_zero;
  logic [DATA_W-1:0]  acc_nxt;
  logic [NBW-1:0]     n_emit;

  assign ival    = IW'(in_ival);
  assign gap_end = (in_idle > min_gap_r) && in_pin;
  assign ram_we  = cmd.edge_upd && frame_open_r && !frame_closed_r;
  assign pair_p1 = pair_r + PIW'(1);
  assign ram_raddr = cmd.rd_b ? pair_p1[EDGE_AW-1:0] : pair_r[EDGE_AW-1:0];
  assign base    = sync_r >> BASE_SHIFT;

  opwd_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (edge_count_r),
    .wdata (ival),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    unique case (cmd.op)
      OP_SYNC: begin
        mul_v = end_r;
        mul_k = tol_r;
      end
      OP_HI: begin
        mul_v = base;
        mul_k = TOL_W'(PCT_HI);
      end
      OP_LO: begin
        mul_v = base;
        mul_k = TOL_W'(PCT_LO);
      end
      OP_HI_TOL: begin
        mul_v = hi_r;
        mul_k = tol_r;
      end
      OP_LO_TOL: begin
        mul_v = lo_r;
        mul_k = tol_r;
      end
      default: begin
        mul_v = '0;
        mul_k = '0;
      end
    endcase
  end

  assign recip_prod = DW'(prod_r) * DW'(RECIP);

  assign bit_one  = near(a_r, hi_lb_r, hi_ub_r) && near(ram_rdata, lo_lb_r, lo_ub_r);
  assign bit_zero = near(a_r, lo_lb_r, lo_ub_r) && near(ram_rdata, hi_lb_r, hi_ub_r);
  assign acc_nxt  = {acc_r[DATA_W-2:0], bit_one};

  assign n_emit = (nbytes_r > NBW'(RESULT_LIMIT)) ? NBW'(RESULT_LIMIT) : nbytes_r;

  always_comb begin
    sts.frame_open   = frame_open_r;
    sts.frame_closed = frame_closed_r;
    sts.timeout      = in_idle > timeout_r;
    sts.sync_ok      = near(sync_r, lo_bnd(end_r, q_r), hi_bnd(end_r, q_r));
    sts.pair_avail   = pair_p1 < PIW'(edge_count_r);
    sts.pair_ok      = bit_one || bit_zero;
    sts.out_last     = (n_emit == '0) || ((emit_idx_r + NBW'(1)) == n_emit);
  end

  assign out_data_byte  = (n_emit == '0) ? '0 : byte_buf_r[emit_idx_r[RLW-1:0]];
  assign out_byte_index = BIDX_W'(emit_idx_r);
  assign out_byte_count = BCNT_W'(nbytes_r);
  assign out_sync_ticks = SYNC_W'(sync_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r     <= TOL_RESET;
      min_gap_r <= MIN_GAP_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOL:     tol_r     <= cfg_data[TOL_W-1:0];
        REG_MIN_GAP: min_gap_r <= cfg_data[MS_W-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r   <= 1'b0;
      frame_closed_r <= 1'b0;
      edge_count_r   <= '0;
      sync_r         <= '0;
      end_r          <= '0;
    end else if (cmd.drop || cmd.finish) begin
      frame_open_r   <= 1'b0;
      frame_closed_r <= 1'b0;
      edge_count_r   <= '0;
    end else if (cmd.edge_upd) begin
      if (frame_open_r && !frame_closed_r) begin
        if (edge_count_r < EDGE_AW'(MAX_EDGES - 1)) begin
          edge_count_r <= edge_count_r + EDGE_AW'(1);
        end
        if (gap_end) begin
          frame_closed_r <= 1'b1;
          end_r          <= ival;
        end
      end else if (!frame_open_r && gap_end) begin
        frame_open_r <= 1'b1;
        sync_r       <= ival;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PW'(mul_v) * PW'(mul_k);
    end
    if (cmd.div) begin
      q_r <= QW'(recip_prod >> RS);
    end
    if (cmd.load) begin
      case (cmd.op)
        OP_HI: hi_r <= IW'(q_r);
        OP_LO: lo_r <= IW'(q_r);
        OP_HI_TOL: begin
          hi_lb_r <= lo_bnd(hi_r, q_r);
          hi_ub_r <= hi_bnd(hi_r, q_r);
        end
        OP_LO_TOL: begin
          lo_lb_r <= lo_bnd(lo_r, q_r);
          lo_ub_r <= hi_bnd(lo_r, q_r);
        end
        default: ;
      endcase
    end
    if (cmd.rd_b) begin
      a_r <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pair_r   <= '0;
      acc_r    <= '0;
      nbits_r  <= '0;
      nbytes_r <= '0;
    end else if (cmd.shift) begin
      pair_r <= pair_r + PIW'(2);
      if (nbits_r == 3'd7) begin
        if (nbytes_r < NBW'(RESULT_LIMIT)) begin
          byte_buf_r[nbytes_r[RLW-1:0]] <= acc_nxt;
        end
        nbytes_r <= nbytes_r + NBW'(1);
        nbits_r  <= '0;
        acc_r    <= '0;
      end else begin
        nbits_r <= nbits_r + 3'd1;
        acc_r   <= acc_nxt;
      end
    end
    if (cmd.finish) begin
      emit_idx_r <= '0;
    end else if (cmd.emit_next) begin
      emit_idx_r <= emit_idx_r + NBW'(1);
    end
  end

endmodule
`default_nettype wire
